// File: rtl/core/qoienc_pkg.sv
`timescale 1ns / 1ps

package qoienc_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned MaxRunDef  = 62;
  localparam int unsigned MaxBytes   = 6;
  localparam int unsigned CntW       = $clog2(MaxBytes + 1);

  localparam logic [1:0] OpIndexTag = 2'b00;
  localparam logic [1:0] OpDiffTag  = 2'b01;
  localparam logic [1:0] OpLumaTag  = 2'b10;
  localparam logic [1:0] OpRunTag   = 2'b11;
  localparam logic [7:0] OpRgb      = 8'hFE;
  localparam logic [7:0] OpRgba     = 8'hFF;

  // red in the low byte, alpha in the high byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam pixel_t ResetPixel = '{alpha: 8'hFF, blue: 8'h00, green: 8'h00, red: 8'h00};

  typedef struct packed {
    logic            en;     // read old entry and write new one
    logic            clr;    // drop every entry back to zero
    logic [IdxW-1:0] idx;
    pixel_t          wdata;
  } tbl_req_t;

  // (3r + 5g + 7b + 11a) mod 64
  function automatic logic [IdxW-1:0] pixel_hash(pixel_t px);
    logic [11:0] sum;
    sum = 12'(px.red) * 12'd3 + 12'(px.green) * 12'd5
        + 12'(px.blue) * 12'd7 + 12'(px.alpha) * 12'd11;
    return sum[IdxW-1:0];
  endfunction

endpackage

// File: rtl/core/qoienc_table.sv
`timescale 1ns / 1ps

module qoienc_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qoienc_pkg::tbl_req_t req_i,
  output qoienc_pkg::pixel_t   rdata_o
);
  import qoienc_pkg::*;

  pixel_t                mem [TableDepth];
  pixel_t                rd_q;
  logic                  rd_vld_q;
  logic [TableDepth-1:0] vld_q;

  // read-before-write: the read returns the entry as it was before this transaction
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      rd_q            <= mem[req_i.idx];
      mem[req_i.idx]  <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (req_i.en) begin
      rd_vld_q <= vld_q[req_i.idx];
      if (req_i.clr) begin
        vld_q <= '0;
      end else begin
        vld_q[req_i.idx] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/core/qoi_pixel_encoder.sv
`timescale 1ns / 1ps
// A pixel's first byte goes through the lookup stage and serializer registers to m_axis.
// Throughput, while m_axis_tready stays high: one pixel per cycle while pixels give at
// most one byte each; otherwise one output byte per cycle, set by the byte serializer.
// The hash table is read and rewritten in the accept cycle, so a new pixel can follow.
// Reset (rst_ni low, async): table, previous pixel and run count to their reset values.
// The same clear happens after every pixel marked by s_axis_tlast.

module qoi_pixel_encoder #(
  parameter int unsigned MAX_RUN = qoienc_pkg::MaxRunDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  input  logic        s_axis_tlast,   // final_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tuser,   // last_of_pixel
  output logic        m_axis_tlast    // image_done
);
  import qoienc_pkg::*;

  localparam logic [5:0] MaxRun = 6'(MAX_RUN);

  // ---------------- accept stage ----------------
  pixel_t          px_in;
  logic            accept;
  logic            eq;
  logic [5:0]      run_inc;
  logic            emit_run;
  logic [7:0]      run_byte;
  logic [IdxW-1:0] hash;
  tbl_req_t        tbl_req;
  pixel_t          tbl_rdata;

  pixel_t     prev_q, prev_d;
  logic [5:0] run_q, run_d;

  // ---------------- lookup stage ----------------
  logic            s1_valid_q, s1_valid_d;
  pixel_t          s1_px_q, s1_prev_q;
  logic            s1_eq_q, s1_emit_q, s1_last_q;
  logic [7:0]      s1_run_byte_q;
  logic [IdxW-1:0] s1_hash_q;
  logic            s1_adv;

  logic [7:0]      dr, dg, db, dr2, dg2, db2, dg32;
  logic [8:0]      drg8, dbg8;
  logic            diff_ok, luma_ok;
  logic [7:0]      op_b  [MaxBytes];
  logic [CntW-1:0] op_n;
  logic [7:0]      bytes [MaxBytes];
  logic [CntW-1:0] n1;

  // ---------------- serializer ----------------
  logic [7:0]      ser_b_q [MaxBytes];
  logic [CntW-1:0] ser_cnt_q;
  logic            ser_img_q;
  logic            ser_free;
  logic            load;
  logic            out_hs;

  assign px_in  = pixel_t'(s_axis_tdata);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign hash   = pixel_hash(px_in);

  always_comb begin
    eq      = (px_in == prev_q);
    run_inc = run_q + 6'd1;
    if (eq) begin
      emit_run = (run_inc >= MaxRun) || s_axis_tlast;
      run_byte = {OpRunTag, run_q};
    end else begin
      emit_run = (run_q != 6'd0);
      run_byte = {OpRunTag, run_q - 6'd1};
    end
  end

  always_comb begin
    prev_d = prev_q;
    run_d  = run_q;
    if (accept) begin
      if (s_axis_tlast) begin
        prev_d = ResetPixel;
        run_d  = '0;
      end else begin
        prev_d = px_in;
        run_d  = (eq && !emit_run) ? run_inc : 6'd0;
      end
    end
  end

  always_comb begin
    tbl_req.en    = accept;
    tbl_req.clr   = s_axis_tlast;
    tbl_req.idx   = hash;
    tbl_req.wdata = px_in;
  end

  qoienc_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= ResetPixel;
      run_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      prev_q     <= prev_d;
      run_q      <= run_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q       <= px_in;
      s1_prev_q     <= prev_q;
      s1_eq_q       <= eq;
      s1_emit_q     <= emit_run;
      s1_run_byte_q <= run_byte;
      s1_last_q     <= s_axis_tlast;
      s1_hash_q     <= hash;
    end
  end

  // channel differences, wrapped to 8 bits
  always_comb begin
    dr   = s1_px_q.red   - s1_prev_q.red;
    dg   = s1_px_q.green - s1_prev_q.green;
    db   = s1_px_q.blue  - s1_prev_q.blue;
    dr2  = dr + 8'd2;
    dg2  = dg + 8'd2;
    db2  = db + 8'd2;
    dg32 = dg + 8'd32;
    // red/blue minus green needs the ninth bit
    drg8 = {dr[7], dr} - {dg[7], dg} + 9'd8;
    dbg8 = {db[7], db} - {dg[7], dg} + 9'd8;
    diff_ok = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
    luma_ok = (dg32 < 8'd64) && (drg8 < 9'd16) && (dbg8 < 9'd16);
  end

  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      op_b[i] = '0;
    end
    if (tbl_rdata == s1_px_q) begin
      op_b[0] = {OpIndexTag, s1_hash_q};
      op_n    = CntW'(1);
    end else if (s1_px_q.alpha != s1_prev_q.alpha) begin
      op_b[0] = OpRgba;
      op_b[1] = s1_px_q.red;
      op_b[2] = s1_px_q.green;
      op_b[3] = s1_px_q.blue;
      op_b[4] = s1_px_q.alpha;
      op_n    = CntW'(5);
    end else if (diff_ok) begin
      op_b[0] = {OpDiffTag, dr2[1:0], dg2[1:0], db2[1:0]};
      op_n    = CntW'(1);
    end else if (luma_ok) begin
      op_b[0] = {OpLumaTag, dg32[5:0]};
      op_b[1] = {drg8[3:0], dbg8[3:0]};
      op_n    = CntW'(2);
    end else begin
      op_b[0] = OpRgb;
      op_b[1] = s1_px_q.red;
      op_b[2] = s1_px_q.green;
      op_b[3] = s1_px_q.blue;
      op_n    = CntW'(4);
    end
  end

  // pending run byte goes ahead of the pixel's own op
  always_comb begin
    bytes[0] = s1_emit_q ? s1_run_byte_q : op_b[0];
    for (int i = 1; i < MaxBytes; i++) begin
      bytes[i] = s1_emit_q ? op_b[i-1] : op_b[i];
    end
    n1 = CntW'(s1_emit_q) + (s1_eq_q ? CntW'(0) : op_n);
  end

  assign out_hs   = m_axis_tvalid && m_axis_tready;
  assign ser_free = (ser_cnt_q == '0) || ((ser_cnt_q == CntW'(1)) && m_axis_tready);
  assign s1_adv   = s1_valid_q && ((n1 == '0) || ser_free);
  assign load     = s1_adv && (n1 != '0);

  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_cnt_q <= '0;
    end else if (load) begin
      ser_cnt_q <= n1;
    end else if (out_hs) begin
      ser_cnt_q <= ser_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_b_q   <= bytes;
      ser_img_q <= s1_last_q;
    end else if (out_hs) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        ser_b_q[i] <= ser_b_q[i+1];
      end
    end
  end

  assign m_axis_tvalid = (ser_cnt_q != '0);
  assign m_axis_tdata  = ser_b_q[0];
  assign m_axis_tuser  = (ser_cnt_q == CntW'(1));
  assign m_axis_tlast  = (ser_cnt_q == CntW'(1)) && ser_img_q;

endmodule

// File: rtl/core/qoienc_checker.sv
`timescale 1ns / 1ps

module qoienc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // end of image is always the end of a pixel's bytes
  a_done_ends_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("image_done without last_of_pixel");

  // input only stalls behind pending output bytes
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output pending");

  // pipeline starts empty out of reset
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

endmodule

bind qoi_pixel_encoder qoienc_checker u_qoienc_checker (.*);

// File: bench/qoi_pixel_encoder_tb.sv
`timescale 1ns / 1ps

module qoi_pixel_encoder_tb;
  import qoienc_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       pixel_end;
    logic       image_end;
  } enc_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  qoi_pixel_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // encoder state as the stream so far implies it
  pixel_t    prev_px;
  int        run_len;
  pixel_t    seen [TableDepth];
  enc_byte_t expected_bytes [$];

  int        errors = 0;
  bit        bursty = 1'b1;
  int        stall_left = 0;
  int        pixels_sent = 0;
  pixel_t    recent_px [$];

  function automatic logic [IdxW-1:0] seen_slot(pixel_t px);
    int sum;
    sum = 3 * px.red + 5 * px.green + 7 * px.blue + 11 * px.alpha;
    return IdxW'(sum % TableDepth);
  endfunction

  function automatic int wrap_delta(logic [7:0] cur, logic [7:0] old);
    logic [7:0] d;
    d = cur - old;
    return int'($signed(d));
  endfunction

  function automatic void clear_encoder();
    prev_px = ResetPixel;
    run_len = 0;
    foreach (seen[i]) seen[i] = '0;
  endfunction

  // work out the op bytes one pixel causes, then advance the state
  function automatic void encode_pixel(pixel_t px, bit fin);
    logic [7:0]      codes [MaxBytes];
    int              n;
    logic [IdxW-1:0] h;
    int              dr, dg, db, drg, dbg;
    enc_byte_t       e;
    n = 0;
    h = seen_slot(px);
    if (px == prev_px) begin
      run_len++;
      if (run_len >= MaxRunDef || fin) begin
        codes[n++] = {OpRunTag, 6'(run_len - 1)};
        run_len = 0;
      end
    end else begin
      if (run_len > 0) begin
        codes[n++] = {OpRunTag, 6'(run_len - 1)};
        run_len = 0;
      end
      dr = wrap_delta(px.red, prev_px.red);
      dg = wrap_delta(px.green, prev_px.green);
      db = wrap_delta(px.blue, prev_px.blue);
      drg = dr - dg;
      dbg = db - dg;
      if (seen[h] == px) begin
        codes[n++] = {OpIndexTag, h};
      end else if (px.alpha != prev_px.alpha) begin
        codes[n++] = OpRgba;
        codes[n++] = px.red;
        codes[n++] = px.green;
        codes[n++] = px.blue;
        codes[n++] = px.alpha;
      end else if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
        codes[n++] = {OpDiffTag, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)};
      end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7
                   && dbg >= -8 && dbg <= 7) begin
        codes[n++] = {OpLumaTag, 6'(dg + 32)};
        codes[n++] = {4'(drg + 8), 4'(dbg + 8)};
      end else begin
        codes[n++] = OpRgb;
        codes[n++] = px.red;
        codes[n++] = px.green;
        codes[n++] = px.blue;
      end
    end
    seen[h] = px;
    prev_px = px;
    for (int k = 0; k < n; k++) begin
      e.code = codes[k];
      e.pixel_end = (k == n - 1);
      e.image_end = (k == n - 1) && fin;
      expected_bytes.push_back(e);
    end
    if (fin) clear_encoder();
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%t: %s", $time, msg);
  endtask

  // byte sink with random backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (bursty && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h user %0b last %0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.code || m_axis_tuser !== want.pixel_end
            || m_axis_tlast !== want.image_end)
          flag_error($sformatf("byte exp %02h/%0b/%0b got %02h/%0b/%0b",
                               want.code, want.pixel_end, want.image_end,
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(pixel_t px, bit fin);
    if (bursty && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tdata = px;
    s_axis_tlast = fin;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_pixel(px, fin);
    pixels_sent++;
    recent_px.push_back(px);
    if (recent_px.size() > 16) void'(recent_px.pop_front());
    @(negedge clk_i);
  endtask

  function automatic pixel_t mk_px(int r, int g, int b, int a);
    pixel_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.alpha = 8'(a);
    return p;
  endfunction

  task automatic test_directed();
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);       // same as reset pixel: run starts
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);
    send_pixel(mk_px(0, 0, 0, 0), 1'b0);         // run flush, then hit on cleared table
    send_pixel(mk_px(255, 255, 255, 255), 1'b0); // alpha change
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);       // seen earlier
    send_pixel(mk_px(1, 0, 254, 255), 1'b0);     // small diff
    send_pixel(mk_px(255, 254, 0, 255), 1'b0);   // wrapped diffs
    send_pixel(mk_px(222, 222, 222, 255), 1'b0); // luma, green at -32
    send_pixel(mk_px(4, 253, 245, 255), 1'b0);   // luma, green +31, r +7, b -8
    send_pixel(mk_px(12, 253, 245, 255), 1'b0);  // just outside luma
    send_pixel(mk_px(12, 253, 245, 128), 1'b0);
    send_pixel(mk_px(12, 253, 245, 128), 1'b1);  // final pixel inside a run
    send_pixel(mk_px(0, 0, 0, 0), 1'b1);         // lone final pixel
    send_pixel(mk_px(0, 0, 0, 255), 1'b1);       // lone final, equal to reset pixel
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);
    send_pixel(mk_px(9, 9, 9, 255), 1'b1);
    send_pixel(mk_px(255, 255, 255, 0), 1'b0);
    send_pixel(mk_px(255, 255, 255, 0), 1'b0);
    send_pixel(mk_px(0, 0, 0, 0), 1'b1);
    send_pixel(mk_px(128, 127, 1, 254), 1'b1);
  endtask

  // runs up to and past the run limit
  task automatic test_long_runs();
    pixel_t p;
    p = mk_px(7, 7, 7, 255);
    send_pixel(p, 1'b0);
    repeat (MaxRunDef + 1) send_pixel(p, 1'b0);
    send_pixel(mk_px(8, 7, 7, 255), 1'b0);
    repeat (5) send_pixel(mk_px(8, 7, 7, 255), 1'b0);
    send_pixel(mk_px(8, 7, 7, 255), 1'b1);
  endtask

  // images built mostly from ops the encoder favors, some fully random pixels
  task automatic test_random_images(int budget, bit allow_idle);
    pixel_t p;
    int     len, dg;
    int     stop_at;
    stop_at = pixels_sent + budget;
    p = ResetPixel;
    while (pixels_sent < stop_at) begin
      len = $urandom_range(1, 30);
      bursty = allow_idle && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: ;
          3: if (recent_px.size() > 0) p = recent_px[$urandom_range(0, recent_px.size() - 1)];
          4, 5: begin
            p.red = p.red + 8'($urandom_range(0, 3) - 2);
            p.green = p.green + 8'($urandom_range(0, 3) - 2);
            p.blue = p.blue + 8'($urandom_range(0, 3) - 2);
          end
          6: begin
            dg = int'($urandom_range(0, 63)) - 32;
            p.green = p.green + 8'(dg);
            p.red = p.red + 8'(dg + int'($urandom_range(0, 15)) - 8);
            p.blue = p.blue + 8'(dg + int'($urandom_range(0, 15)) - 8);
          end
          7: p.alpha = 8'($urandom);
          default: begin
            p.red = 8'($urandom);
            p.green = 8'($urandom);
            p.blue = 8'($urandom);
            if ($urandom_range(0, 1) == 0) p.alpha = 8'($urandom);
          end
        endcase
        send_pixel(p, i == len - 1);
      end
    end
  endtask

  initial begin
    clear_encoder();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_long_runs();
    test_random_images(220, 1'b1);
    test_random_images(50, 1'b0);
    bursty = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("qoi_pixel_encoder: match");
    end else begin
      $display("qoi_pixel_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("qoi_pixel_encoder: mismatch");
    $finish;
  end

endmodule
